[src/mp2x2_pkg.sv]
// ----------------------------------------------------------------------------
// mp2x2_pkg: shared types and constants for the 2x2 max pooling block
// Field widths, configuration register indexes and result slot positions.
// ----------------------------------------------------------------------------
package mp2x2_pkg;

    // Widths of the stream fields.
    localparam int SAMPLE_W    = 8;
    localparam int ROW_W       = 7;
    localparam int COL_W       = 7;
    localparam int CHAN_W      = 6;
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int NUM_RES     = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [NUM_RES-1:0]         res_mask_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_HEIGHT   = 2'd0;
    localparam cfg_index_t CFG_WIDTH    = 2'd1;
    localparam cfg_index_t CFG_CHANNELS = 2'd2;

    // Result slots caused by one item, in output raster order.
    localparam int RES_INTERIOR = 0;
    localparam int RES_RIGHT    = 1;
    localparam int RES_BOTTOM   = 2;
    localparam int RES_CORNER   = 3;

    // Signed maximum of two activations.
    function automatic sample_t max2(sample_t a, sample_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

[src/max_pool_2x2_stride1_same.sv]
// ----------------------------------------------------------------------------
// max_pool_2x2_stride1_same: streaming 2x2 stride-1 max pooling, padded below and right
// Path: an accepted item is registered in the work stage, and each of its results then in the result register.
// Throughput: one item per cycle while m_ready keeps the output free; an item with k
// results holds the input while the single result register drains one result a cycle.
// Reset: synchronous, active low; 1x1x1 frame, counters at zero, buffers kept.
// ----------------------------------------------------------------------------
module max_pool_2x2_stride1_same
    import mp2x2_pkg::*;
#(
    parameter int MAX_WIDTH    = 128,
    parameter int MAX_HEIGHT   = 128,
    parameter int MAX_CHANNELS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_t               s_sample,

    output logic                  m_valid,
    input  logic                  m_ready,
    output sample_t               m_pooled,
    output logic [ROW_W-1:0]      m_out_row,
    output logic [COL_W-1:0]      m_out_col,
    output logic [CHAN_W-1:0]     m_out_channel,
    output logic                  m_last_of_run
);

    localparam int RW         = $clog2(MAX_HEIGHT);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int CHW        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int LAW        = $clog2(LINE_DEPTH);

    // Frame geometry, stored as the last index of each dimension.
    logic [RW-1:0]  height_last_reg, height_last_next;
    logic [CW-1:0]  width_last_reg, width_last_next;
    logic [CHW-1:0] chan_last_reg, chan_last_next;

    // Position of the next item and its place in the row buffer.
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [CHW-1:0] chan_reg, chan_next;
    logic [LAW-1:0] line_ptr_reg, line_ptr_next;

    // Work stage: one item with its neighbors and pending results.
    logic           s1_valid_reg, s1_valid_next;
    res_mask_t      s1_pend_reg, s1_pend_next;
    sample_t        s1_cur_reg, s1_up_reg, s1_left_reg, s1_upleft_reg;
    logic [RW-1:0]  s1_row_reg;
    logic [CW-1:0]  s1_col_reg;
    logic [CHW-1:0] s1_chan_reg;

    // Result register.
    logic           m_valid_reg, m_valid_next;
    sample_t        m_pooled_reg;
    logic [ROW_W-1:0]  m_out_row_reg;
    logic [COL_W-1:0]  m_out_col_reg;
    logic [CHAN_W-1:0] m_out_channel_reg;
    logic           m_last_reg;

    // Memories: one image row, and the previous pixel's {cur, up} per channel.
    sample_t                        line_mem [LINE_DEPTH];
    logic [2*SAMPLE_W-1:0]          prev_mem [MAX_CHANNELS];

    logic       cfg_we, cfg_restart, s_accept;
    logic       out_free, out_load, s1_done;
    res_mask_t  pend_in, pend_sel, pend_rest;
    sample_t    res_val;
    logic [RW-1:0] res_row;
    logic [CW-1:0] res_col;
    logic [6:0] chan_data;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign chan_data = cfg_data[6:0];
    assign s_accept  = s_valid && s_ready;

    // Register writes: zero acts as one, large values saturate; channels use data bits 6:0 only.
    always_comb begin
        height_last_next = height_last_reg;
        width_last_next  = width_last_reg;
        chan_last_next   = chan_last_reg;
        cfg_restart      = 1'b0;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_HEIGHT: begin
                    cfg_restart = 1'b1;
                    if (cfg_data == '0) begin
                        height_last_next = '0;
                    end else if (32'(cfg_data) > MAX_HEIGHT) begin
                        height_last_next = RW'(MAX_HEIGHT - 1);
                    end else begin
                        height_last_next = RW'(cfg_data - 8'd1);
                    end
                end
                CFG_WIDTH: begin
                    cfg_restart = 1'b1;
                    if (cfg_data == '0) begin
                        width_last_next = '0;
                    end else if (32'(cfg_data) > MAX_WIDTH) begin
                        width_last_next = CW'(MAX_WIDTH - 1);
                    end else begin
                        width_last_next = CW'(cfg_data - 8'd1);
                    end
                end
                CFG_CHANNELS: begin
                    cfg_restart = 1'b1;
                    if (chan_data == '0) begin
                        chan_last_next = '0;
                    end else if (32'(chan_data) > MAX_CHANNELS) begin
                        chan_last_next = CHW'(MAX_CHANNELS - 1);
                    end else begin
                        chan_last_next = CHW'(chan_data - 7'd1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Raster counters; the row buffer pointer restarts with every row.
    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        chan_next     = chan_reg;
        line_ptr_next = line_ptr_reg;
        priority if (cfg_restart) begin
            row_next      = '0;
            col_next      = '0;
            chan_next     = '0;
            line_ptr_next = '0;
        end else if (s_accept) begin
            if (chan_reg != chan_last_reg) begin
                chan_next     = chan_reg + 1'b1;
                line_ptr_next = line_ptr_reg + 1'b1;
            end else begin
                chan_next = '0;
                if (col_reg != width_last_reg) begin
                    col_next      = col_reg + 1'b1;
                    line_ptr_next = line_ptr_reg + 1'b1;
                end else begin
                    col_next      = '0;
                    line_ptr_next = '0;
                    row_next      = (row_reg == height_last_reg) ? '0 : row_reg + 1'b1;
                end
            end
        end
    end

    // Results that the incoming item completes.
    always_comb begin
        pend_in = '0;
        pend_in[RES_INTERIOR] = (row_reg != '0) && (col_reg != '0);
        pend_in[RES_RIGHT]    = (row_reg != '0) && (col_reg == width_last_reg);
        pend_in[RES_BOTTOM]   = (row_reg == height_last_reg) && (col_reg != '0);
        pend_in[RES_CORNER]   = (row_reg == height_last_reg) && (col_reg == width_last_reg);
    end

    // Pick the first pending result of the work stage.
    assign pend_sel  = s1_pend_reg & (~s1_pend_reg + 1'b1);
    assign pend_rest = s1_pend_reg & ~pend_sel;

    always_comb begin
        priority if (s1_pend_reg[RES_INTERIOR]) begin
            res_val = max2(max2(s1_upleft_reg, s1_up_reg), max2(s1_left_reg, s1_cur_reg));
            res_row = s1_row_reg - 1'b1;
            res_col = s1_col_reg - 1'b1;
        end else if (s1_pend_reg[RES_RIGHT]) begin
            res_val = max2(s1_up_reg, s1_cur_reg);
            res_row = s1_row_reg - 1'b1;
            res_col = s1_col_reg;
        end else if (s1_pend_reg[RES_BOTTOM]) begin
            res_val = max2(s1_left_reg, s1_cur_reg);
            res_row = s1_row_reg;
            res_col = s1_col_reg - 1'b1;
        end else begin
            res_val = s1_cur_reg;
            res_row = s1_row_reg;
            res_col = s1_col_reg;
        end
    end

    // Handshake between the work stage and the result register.
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = s1_valid_reg && (s1_pend_reg != '0) && out_free;
    assign s1_done  = s1_valid_reg && (pend_rest == '0) && ((s1_pend_reg == '0) || out_free);
    assign s_ready  = !s1_valid_reg || s1_done;

    always_comb begin
        s1_valid_next = s_accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        s1_pend_next  = s_accept ? pend_in : (out_load ? pend_rest : s1_pend_reg);
        m_valid_next  = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_last_reg <= '0;
            width_last_reg  <= '0;
            chan_last_reg   <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            chan_reg        <= '0;
            line_ptr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            s1_pend_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            height_last_reg <= height_last_next;
            width_last_reg  <= width_last_next;
            chan_last_reg   <= chan_last_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            chan_reg        <= chan_next;
            line_ptr_reg    <= line_ptr_next;
            s1_valid_reg    <= s1_valid_next;
            s1_pend_reg     <= s1_pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Row buffer: read the element one row up, then replace it.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_up_reg              <= line_mem[line_ptr_reg];
            line_mem[line_ptr_reg] <= s_sample;
        end
    end

    // Previous pixel store, written as an item leaves the work stage.
    // A read in the same cycle of the same channel takes the new data.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (s1_done && (s1_chan_reg == chan_reg)) begin
                {s1_left_reg, s1_upleft_reg} <= {s1_cur_reg, s1_up_reg};
            end else begin
                {s1_left_reg, s1_upleft_reg} <= prev_mem[chan_reg];
            end
        end
        if (s1_done) begin
            prev_mem[s1_chan_reg] <= {s1_cur_reg, s1_up_reg};
        end
    end

    // Work stage payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cur_reg  <= s_sample;
            s1_row_reg  <= row_reg;
            s1_col_reg  <= col_reg;
            s1_chan_reg <= chan_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pooled_reg      <= res_val;
            m_out_row_reg     <= ROW_W'(res_row);
            m_out_col_reg     <= COL_W'(res_col);
            m_out_channel_reg <= CHAN_W'(s1_chan_reg);
            m_last_reg        <= (pend_rest == '0);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pooled      = m_pooled_reg;
    assign m_out_row     = m_out_row_reg;
    assign m_out_col     = m_out_col_reg;
    assign m_out_channel = m_out_channel_reg;
    assign m_last_of_run = m_last_reg;

    // The row buffer pointer is at zero at the start of every row.
    a_line_ptr_row_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg == '0 && chan_reg == '0) |-> (line_ptr_reg == '0))
        else $error("row buffer pointer out of step with the raster counters");

    // A right column result only comes from the last column.
    a_right_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_pend_reg[RES_RIGHT]) |-> (s1_col_reg == width_last_reg))
        else $error("right column result pending away from the last column");

    // The input stalls only while results are still pending.
    a_stall_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s1_pend_reg != '0))
        else $error("input stalled with no pending results");

    // A finished item with no successor leaves the work stage empty.
    a_stage_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_done && !s_accept) |=> !s1_valid_reg)
        else $error("work stage kept an item after it finished");

endmodule
